>>> design/tcc_pkg.sv
`default_nettype none

package tcc_pkg;

  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned OutWidth      = 48;
  localparam int unsigned QueueDepth    = 4;

  // op codes; any other code selects the circumcenter
  localparam logic [1:0] OP_CENTROID = 2'd0;
  localparam logic [1:0] OP_ORTHO    = 2'd1;
  localparam logic [1:0] OP_CIRCUM   = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_COLLINEAR = 2'd1;
  localparam logic [1:0] STATUS_SAT       = 2'd2;

  typedef struct packed {
    logic collinear;
    logic subtract;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

`default_nettype wire

>>> design/tcc_front.sv
`default_nettype none

module tcc_front #(
  parameter int unsigned COORD_WIDTH = tcc_pkg::CoordWidthDef,
  parameter int unsigned FRAC_BITS   = tcc_pkg::FracBitsDef,
  localparam int unsigned CW  = COORD_WIDTH,
  localparam int unsigned NW  = 3 * CW + 4,
  localparam int unsigned DMW = 2 * CW + 4,
  localparam int unsigned MW  = NW + FRAC_BITS + 2,
  localparam int unsigned BW  = CW + FRAC_BITS + 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  logic [1:0]             op_i,
  input  logic signed [CW-1:0]   ax_i,
  input  logic signed [CW-1:0]   ay_i,
  input  logic signed [CW-1:0]   bx_i,
  input  logic signed [CW-1:0]   by_coord_i,
  input  logic signed [CW-1:0]   cx_i,
  input  logic signed [CW-1:0]   cy_i,
  input  logic                   full_i,
  output logic                   push_o,
  output tcc_pkg::ctl_t          ctl_o,
  output logic [MW-1:0]          mx_o,
  output logic [MW-1:0]          my_o,
  output logic [DMW:0]           d_o,
  output logic signed [BW-1:0]   basex_o,
  output logic signed [BW-1:0]   basey_o
);

  localparam int unsigned DW  = CW + 1;
  localparam int unsigned SW  = CW + 2;
  localparam int unsigned DTW = 2 * CW + 3;
  localparam int unsigned SQW = 2 * CW + 2;

  logic adv;
  logic a_vld_q, b_vld_q, c_vld_q;

  // stage A: differences and sums
  logic [1:0] op_a_q;
  logic signed [DW-1:0] dbx_a_q, dby_a_q, dcx_a_q, dcy_a_q;
  logic signed [SW-1:0] sx_a_q, sy_a_q, hx_a_q, hy_a_q;
  logic signed [CW-1:0] ax_a_q, ay_a_q;

  // stage B: determinant and squared side lengths
  logic [1:0] op_b_q;
  logic signed [DW-1:0] dbx_b_q, dby_b_q, dcx_b_q, dcy_b_q;
  logic signed [DTW-1:0] det_b_q;
  logic signed [SQW-1:0] b2_b_q, c2_b_q;
  logic signed [SW-1:0] sx_b_q, sy_b_q, hx_b_q, hy_b_q;
  logic signed [CW-1:0] ax_b_q, ay_b_q;

  // stage C: bisector numerators
  logic [1:0] op_c_q;
  logic signed [DTW-1:0] det_c_q;
  logic signed [NW-1:0] nx_c_q, ny_c_q;
  logic signed [SW-1:0] sx_c_q, sy_c_q, hx_c_q, hy_c_q;
  logic signed [CW-1:0] ax_c_q, ay_c_q;

  assign adv     = !(c_vld_q && full_i);
  assign stall_o = !adv;
  assign push_o  = c_vld_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_a_q  <= op_i;
      dbx_a_q <= DW'(bx_i) - DW'(ax_i);
      dby_a_q <= DW'(by_coord_i) - DW'(ay_i);
      dcx_a_q <= DW'(cx_i) - DW'(ax_i);
      dcy_a_q <= DW'(cy_i) - DW'(ay_i);
      sx_a_q  <= SW'(ax_i) + SW'(bx_i) + SW'(cx_i);
      sy_a_q  <= SW'(ay_i) + SW'(by_coord_i) + SW'(cy_i);
      hx_a_q  <= SW'(bx_i) + SW'(cx_i) - SW'(ax_i);
      hy_a_q  <= SW'(by_coord_i) + SW'(cy_i) - SW'(ay_i);
      ax_a_q  <= ax_i;
      ay_a_q  <= ay_i;

      op_b_q  <= op_a_q;
      dbx_b_q <= dbx_a_q;
      dby_b_q <= dby_a_q;
      dcx_b_q <= dcx_a_q;
      dcy_b_q <= dcy_a_q;
      det_b_q <= DTW'(dbx_a_q) * DTW'(dcy_a_q) - DTW'(dby_a_q) * DTW'(dcx_a_q);
      b2_b_q  <= SQW'(dbx_a_q) * SQW'(dbx_a_q) + SQW'(dby_a_q) * SQW'(dby_a_q);
      c2_b_q  <= SQW'(dcx_a_q) * SQW'(dcx_a_q) + SQW'(dcy_a_q) * SQW'(dcy_a_q);
      sx_b_q  <= sx_a_q;
      sy_b_q  <= sy_a_q;
      hx_b_q  <= hx_a_q;
      hy_b_q  <= hy_a_q;
      ax_b_q  <= ax_a_q;
      ay_b_q  <= ay_a_q;

      op_c_q  <= op_b_q;
      det_c_q <= det_b_q;
      nx_c_q  <= NW'(dcy_b_q) * NW'(b2_b_q) - NW'(dby_b_q) * NW'(c2_b_q);
      ny_c_q  <= NW'(dbx_b_q) * NW'(c2_b_q) - NW'(dcx_b_q) * NW'(b2_b_q);
      sx_c_q  <= sx_b_q;
      sy_c_q  <= sy_b_q;
      hx_c_q  <= hx_b_q;
      hy_c_q  <= hy_b_q;
      ax_c_q  <= ax_b_q;
      ay_c_q  <= ay_b_q;
    end
  end

  // classify: every op becomes round(n * 2^F / d) added to or taken from a base
  logic signed [NW-1:0]  nx_sel, ny_sel;
  logic signed [DMW-1:0] d_sel;
  logic [NW-1:0]         nxm, nym;
  logic [DMW-1:0]        dm;

  always_comb begin
    case (op_c_q)
      tcc_pkg::OP_CENTROID: begin
        nx_sel         = NW'(sx_c_q);
        ny_sel         = NW'(sy_c_q);
        d_sel          = DMW'(3);
        basex_o        = '0;
        basey_o        = '0;
        ctl_o.subtract = 1'b0;
      end
      tcc_pkg::OP_ORTHO: begin
        nx_sel         = nx_c_q;
        ny_sel         = ny_c_q;
        d_sel          = DMW'(det_c_q);
        basex_o        = BW'(hx_c_q) <<< FRAC_BITS;
        basey_o        = BW'(hy_c_q) <<< FRAC_BITS;
        ctl_o.subtract = 1'b1;
      end
      default: begin
        nx_sel         = nx_c_q;
        ny_sel         = ny_c_q;
        d_sel          = DMW'(det_c_q) <<< 1;
        basex_o        = BW'(ax_c_q) <<< FRAC_BITS;
        basey_o        = BW'(ay_c_q) <<< FRAC_BITS;
        ctl_o.subtract = 1'b0;
      end
    endcase
    nxm             = nx_sel[NW-1] ? -nx_sel : nx_sel;
    nym             = ny_sel[NW-1] ? -ny_sel : ny_sel;
    dm              = d_sel[DMW-1] ? -d_sel : d_sel;
    ctl_o.collinear = (det_c_q == '0);
    ctl_o.neg_x     = nx_sel[NW-1] ^ d_sel[DMW-1];
    ctl_o.neg_y     = ny_sel[NW-1] ^ d_sel[DMW-1];
    // adding |d| before dividing by 2|d| rounds half away from zero
    mx_o            = (MW'(nxm) << (FRAC_BITS + 1)) + MW'(dm);
    my_o            = (MW'(nym) << (FRAC_BITS + 1)) + MW'(dm);
    d_o             = {dm, 1'b0};
  end

endmodule

`default_nettype wire

>>> design/tcc_queue.sv
`default_nettype none

module tcc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = tcc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;

  assign full_o  = (cnt_q == (AW + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/tcc_div.sv
`default_nettype none

module tcc_div #(
  parameter int unsigned COORD_WIDTH = tcc_pkg::CoordWidthDef,
  parameter int unsigned FRAC_BITS   = tcc_pkg::FracBitsDef,
  localparam int unsigned CW  = COORD_WIDTH,
  localparam int unsigned NW  = 3 * CW + 4,
  localparam int unsigned DMW = 2 * CW + 4,
  localparam int unsigned MW  = NW + FRAC_BITS + 2,
  localparam int unsigned BW  = CW + FRAC_BITS + 3,
  localparam int unsigned OW  = tcc_pkg::OutWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 pop_o,
  input  tcc_pkg::ctl_t        ctl_i,
  input  logic [MW-1:0]        mx_i,
  input  logic [MW-1:0]        my_i,
  input  logic [DMW:0]         d_i,
  input  logic signed [BW-1:0] basex_i,
  input  logic signed [BW-1:0] basey_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [OW-1:0]        px_o,
  output logic [OW-1:0]        py_o,
  output logic [1:0]           status_o
);

  // quotient bits kept; anything larger lands far outside the output range
  localparam int unsigned QW = (CW + FRAC_BITS + 2 > OW + 1) ? CW + FRAC_BITS + 2 : OW + 1;
  localparam int unsigned XW = QW + DMW + 2;
  localparam int unsigned RW = QW + 3;
  localparam logic signed [RW-1:0] OutMax = {{(RW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
  localparam logic signed [RW-1:0] OutMin = {{(RW - OW + 1){1'b1}}, {(OW - 1){1'b0}}};

  logic                 adv;
  logic [QW:0]          vld_q;
  tcc_pkg::ctl_t        ctl_q  [QW+1];
  logic [MW-1:0]        remx_q [QW+1];
  logic [MW-1:0]        remy_q [QW+1];
  logic [QW-1:0]        qx_q   [QW+1];
  logic [QW-1:0]        qy_q   [QW+1];
  logic [DMW:0]         d_q    [QW+1];
  logic signed [BW-1:0] bx_q   [QW+1];
  logic signed [BW-1:0] by_q   [QW+1];
  logic                 ovx_q  [QW+1];
  logic                 ovy_q  [QW+1];

  logic                 out_vld_q;
  logic [OW-1:0]        px_q, py_q;
  logic [1:0]           status_q;

  assign adv   = !(out_vld_q && stall_i);
  assign pop_o = adv && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[QW-1:0], valid_i};
      out_vld_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0]  <= ctl_i;
      remx_q[0] <= mx_i;
      remy_q[0] <= my_i;
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      d_q[0]    <= d_i;
      bx_q[0]   <= basex_i;
      by_q[0]   <= basey_i;
      ovx_q[0]  <= XW'(mx_i) >= (XW'(d_i) << QW);
      ovy_q[0]  <= XW'(my_i) >= (XW'(d_i) << QW);
    end
  end

  // one restoring quotient bit per stage, most significant first
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [XW-1:0] shd, trx, try_v;
    logic          takex, takey;

    assign shd   = XW'(d_q[k-1]) << (QW - k);
    assign trx   = XW'(remx_q[k-1]) - shd;
    assign try_v = XW'(remy_q[k-1]) - shd;
    assign takex = XW'(remx_q[k-1]) >= shd;
    assign takey = XW'(remy_q[k-1]) >= shd;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ctl_q[k]  <= ctl_q[k-1];
        remx_q[k] <= takex ? MW'(trx) : remx_q[k-1];
        remy_q[k] <= takey ? MW'(try_v) : remy_q[k-1];
        qx_q[k]   <= {qx_q[k-1][QW-2:0], takex};
        qy_q[k]   <= {qy_q[k-1][QW-2:0], takey};
        d_q[k]    <= d_q[k-1];
        bx_q[k]   <= bx_q[k-1];
        by_q[k]   <= by_q[k-1];
        ovx_q[k]  <= ovx_q[k-1];
        ovy_q[k]  <= ovy_q[k-1];
      end
    end
  end

  // {saturated, value}
  function automatic logic [OW:0] finish(input logic ov, input logic neg, input logic sub,
                                         input logic [QW-1:0] q,
                                         input logic signed [BW-1:0] base);
    logic signed [RW-1:0] t;
    logic signed [RW-1:0] r;
    t = neg ? -RW'(q) : RW'(q);
    r = sub ? RW'(base) - t : RW'(base) + t;
    if (ov) begin
      finish = (neg ^ sub) ? {1'b1, OutMin[OW-1:0]} : {1'b1, OutMax[OW-1:0]};
    end else if (r > OutMax) begin
      finish = {1'b1, OutMax[OW-1:0]};
    end else if (r < OutMin) begin
      finish = {1'b1, OutMin[OW-1:0]};
    end else begin
      finish = {1'b0, r[OW-1:0]};
    end
  endfunction

  logic [OW:0] fx, fy;

  assign fx = finish(ovx_q[QW], ctl_q[QW].neg_x, ctl_q[QW].subtract, qx_q[QW], bx_q[QW]);
  assign fy = finish(ovy_q[QW], ctl_q[QW].neg_y, ctl_q[QW].subtract, qy_q[QW], by_q[QW]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (ctl_q[QW].collinear) begin
        px_q     <= '0;
        py_q     <= '0;
        status_q <= tcc_pkg::STATUS_COLLINEAR;
      end else begin
        px_q     <= fx[OW-1:0];
        py_q     <= fy[OW-1:0];
        status_q <= (fx[OW] || fy[OW]) ? tcc_pkg::STATUS_SAT : tcc_pkg::STATUS_OK;
      end
    end
  end

  assign valid_o  = out_vld_q;
  assign px_o     = px_q;
  assign py_o     = py_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

>>> design/triangle_centre_calculator.sv
// channel  dir  handshake          payload
// input    in   valid_i / stall_o  op_i ax_i ay_i bx_i by_coord_i cx_i cy_i
// output   out  valid_o / stall_i  px_o py_o status_o
//
// One triangle per cycle sustained while stall_i is low. From input to valid_o, with
// QW = max(49, CW+F+2): 3 front stages, the queue write, QW + 1 divider stages
// (an input register, then one quotient bit each) and the output register.
// rst_ni clears pipeline valids and queue pointers only; no clearing pass.
// stall_i freezes the divider back end; the front keeps filling the 4-entry
// queue and raises stall_o only when the queue is full and its last stage holds.
`default_nettype none

module triangle_centre_calculator #(
  parameter int unsigned COORD_WIDTH = tcc_pkg::CoordWidthDef,
  parameter int unsigned FRAC_BITS   = tcc_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [1:0]                    op_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_coord_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [tcc_pkg::OutWidth-1:0]  px_o,
  output logic [tcc_pkg::OutWidth-1:0]  py_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned NW  = 3 * CW + 4;
  localparam int unsigned DMW = 2 * CW + 4;
  localparam int unsigned MW  = NW + FRAC_BITS + 2;
  localparam int unsigned BW  = CW + FRAC_BITS + 3;
  localparam int unsigned EW  = $bits(tcc_pkg::ctl_t) + 2 * MW + DMW + 1 + 2 * BW;

  tcc_pkg::ctl_t        f_ctl, b_ctl;
  logic [MW-1:0]        f_mx, f_my, b_mx, b_my;
  logic [DMW:0]         f_d, b_d;
  logic signed [BW-1:0] f_bx, f_by, b_bx, b_by;
  logic                 push, pop, full, empty;
  logic [EW-1:0]        wdata, rdata;

  tcc_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .op_i,
    .ax_i, .ay_i, .bx_i, .by_coord_i, .cx_i, .cy_i,
    .full_i  (full),
    .push_o  (push),
    .ctl_o   (f_ctl),
    .mx_o    (f_mx),
    .my_o    (f_my),
    .d_o     (f_d),
    .basex_o (f_bx),
    .basey_o (f_by)
  );

  assign wdata = {f_ctl, f_mx, f_my, f_d, f_bx, f_by};

  tcc_queue #(
    .WIDTH(EW),
    .DEPTH(tcc_pkg::QueueDepth)
  ) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rdata)
  );

  assign {b_ctl, b_mx, b_my, b_d, b_bx, b_by} = rdata;

  tcc_div #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i, .rst_ni,
    .valid_i (!empty),
    .pop_o   (pop),
    .ctl_i   (b_ctl),
    .mx_i    (b_mx),
    .my_i    (b_my),
    .d_i     (b_d),
    .basex_i (b_bx),
    .basey_i (b_by),
    .valid_o, .stall_i, .px_o, .py_o, .status_o
  );

endmodule

`default_nettype wire

>>> design/tcc_checker.sv
`default_nettype none

module tcc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         valid_o,
  input logic                         stall_i,
  input logic [tcc_pkg::OutWidth-1:0] px_o,
  input logic [tcc_pkg::OutWidth-1:0] py_o,
  input logic [1:0]                   status_o
);

  localparam logic [tcc_pkg::OutWidth-1:0] Max = {1'b0, {(tcc_pkg::OutWidth - 1){1'b1}}};
  localparam logic [tcc_pkg::OutWidth-1:0] Min = {1'b1, {(tcc_pkg::OutWidth - 1){1'b0}}};

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result transaction dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(px_o) && $stable(py_o) && $stable(status_o))
    else $error("result payload changed while stalled");

  a_collinear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == tcc_pkg::STATUS_COLLINEAR |-> px_o == '0 && py_o == '0)
    else $error("collinear result not zero");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == tcc_pkg::STATUS_SAT
      |-> px_o == Max || px_o == Min || py_o == Max || py_o == Min)
    else $error("saturated result without a clamped coordinate");

endmodule

bind triangle_centre_calculator tcc_checker u_tcc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_o  (valid_o),
  .stall_i  (stall_i),
  .px_o     (px_o),
  .py_o     (py_o),
  .status_o (status_o)
);

`default_nettype wire
